>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> hdl/fspp_pkg.sv
// ----------------------------------------------------------------------------
// fspp_pkg
// frame layout constants and shared types of the sensor packet parser
// ----------------------------------------------------------------------------
package fspp_pkg;

	localparam logic [7:0] HDR0_BYTE  = 8'hAA;
	localparam logic [7:0] HDR1_BYTE  = 8'hC0;
	localparam logic [7:0] TRAIL_BYTE = 8'hAB;

	localparam int POS_W = 4;
	typedef logic [POS_W-1:0] pos_t;

	// frame byte positions
	localparam pos_t POS_HDR0   = 4'd0;
	localparam pos_t POS_HDR1   = 4'd1;
	localparam pos_t POS_VOLT_L = 4'd2;
	localparam pos_t POS_VOLT_H = 4'd3;
	localparam pos_t POS_CURR_L = 4'd4;
	localparam pos_t POS_CURR_H = 4'd5;
	localparam pos_t POS_SPARE0 = 4'd6;
	localparam pos_t POS_SPARE1 = 4'd7;
	localparam pos_t POS_CSUM   = 4'd8;
	localparam pos_t POS_TRAIL  = 4'd9;

	// outcome of the word held in the input register
	typedef struct packed {
		logic        hit;
		logic [15:0] voltage;
		logic [15:0] current;
	} step_res_t;

endpackage

>>> hdl/fspp_in_reg.sv
// ----------------------------------------------------------------------------
// fspp_in_reg
// input register holding one received word until the frame step takes it
// ----------------------------------------------------------------------------
module fspp_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_ready,
	input  logic [7:0] rx_byte,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign byte_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

>>> hdl/fspp_frame_step.sv
// ----------------------------------------------------------------------------
// fspp_frame_step
// frame position, running checksum and field assembly, one word per take
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fspp_frame_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  logic [7:0]           byte_s1,
	input  logic                 take,
	output fspp_pkg::step_res_t  res
);

	fspp_pkg::pos_t position_q;
	logic [7:0]     checksum_q;
	logic [15:0]    voltage_q;
	logic [15:0]    current_q;

	fspp_pkg::pos_t pos_next;
	logic [7:0]     csum_next;
	logic [15:0]    volt_next;
	logic [15:0]    curr_next;
	logic           hit;

	always_comb begin
		pos_next  = position_q + 4'd1;
		csum_next = checksum_q + byte_s1;
		volt_next = voltage_q;
		curr_next = current_q;
		hit       = 1'b0;
		case (position_q)
			fspp_pkg::POS_HDR1: begin
				if (byte_s1 != fspp_pkg::HDR1_BYTE) begin
					pos_next = fspp_pkg::POS_HDR0;
				end
				csum_next = '0;
			end
			fspp_pkg::POS_VOLT_L: begin
				volt_next = {8'h00, byte_s1};
				csum_next = byte_s1;
			end
			fspp_pkg::POS_VOLT_H: begin
				volt_next = {byte_s1, voltage_q[7:0]};
			end
			fspp_pkg::POS_CURR_L: begin
				curr_next = {8'h00, byte_s1};
			end
			fspp_pkg::POS_CURR_H: begin
				curr_next = {byte_s1, current_q[7:0]};
			end
			fspp_pkg::POS_SPARE0, fspp_pkg::POS_SPARE1: begin
			end
			fspp_pkg::POS_CSUM: begin
				csum_next = checksum_q;
				if (byte_s1 != checksum_q) begin
					pos_next  = fspp_pkg::POS_HDR0;
					csum_next = '0;
				end
			end
			fspp_pkg::POS_TRAIL: begin
				pos_next  = fspp_pkg::POS_HDR0;
				csum_next = '0;
				hit       = (byte_s1 == fspp_pkg::TRAIL_BYTE);
			end
			default: begin
				// first header byte; unused positions behave the same
				pos_next  = (byte_s1 == fspp_pkg::HDR0_BYTE) ? fspp_pkg::POS_HDR1
				                                             : fspp_pkg::POS_HDR0;
				csum_next = '0;
			end
		endcase
	end

	assign res.hit     = valid_s1 && hit;
	assign res.voltage = voltage_q;
	assign res.current = current_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= fspp_pkg::POS_HDR0;
			checksum_q <= '0;
			voltage_q  <= '0;
			current_q  <= '0;
		end else if (take) begin
			position_q <= pos_next;
			checksum_q <= csum_next;
			voltage_q  <= volt_next;
			current_q  <= curr_next;
		end
	end

	`ASSERT_NEVER(a_pos_range, clk, arst_n, position_q > fspp_pkg::POS_TRAIL)
	`ASSERT_PROP(a_hit_at_trailer, clk, arst_n, res.hit |-> position_q == fspp_pkg::POS_TRAIL)
	`ASSERT_PROP(a_restart_after_hit, clk, arst_n, (take && res.hit) |=> position_q == fspp_pkg::POS_HDR0)
	`ASSERT_NEVER(a_take_without_word, clk, arst_n, take && !valid_s1)

endmodule

>>> hdl/fspp_out_reg.sv
// ----------------------------------------------------------------------------
// fspp_out_reg
// result register, holds a decoded frame until the receiver takes it
// ----------------------------------------------------------------------------
module fspp_out_reg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [15:0] voltage,
	input  logic [15:0] current,
	output logic        free,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] voltage_tenths,
	output logic [15:0] current_tenths
);

	logic        result_valid_q;
	logic [15:0] voltage_q;
	logic [15:0] current_q;

	assign free           = !result_valid_q || result_ready;
	assign result_valid   = result_valid_q;
	assign voltage_tenths = voltage_q;
	assign current_tenths = current_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			voltage_q <= voltage;
			current_q <= current;
		end
	end

endmodule

>>> hdl/framed_sensor_packet_parser.sv
// ----------------------------------------------------------------------------
// framed_sensor_packet_parser
// byte stream parser for a 10-word sensor frame with checksum and trailer
// ----------------------------------------------------------------------------
// usage
//   input channel: rx_byte with byte_valid / byte_ready, one serial word each
//   output channel: voltage_tenths, current_tenths with result_valid /
//   result_ready, one result per complete frame (header, checksum, trailer ok)
//   frame: aa c0, voltage lo/hi, current lo/hi, two spare, checksum, ab
//   a mismatching word sends the parser back to the first header position;
//   that word is dropped, the next one is checked as a header
// timing
//   one word per cycle sustained while no trailer is stalled; a word is held in
//   the input register until taken, then folded into the frame state, and a
//   frame result is registered onto result_valid as its trailer is folded in
// reset
//   arst_n clears position, checksum and both handshake valids at once
// stalls
//   a held result blocks only a trailer that would complete another frame;
//   other words keep flowing, and a stalled trailer holds the input register
// ----------------------------------------------------------------------------
module framed_sensor_packet_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  rx_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] voltage_tenths,
	output logic [15:0] current_tenths
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                take;
	logic                out_free;
	fspp_pkg::step_res_t res;

	// the held word moves on unless it completes a frame while the result slot is full and not being read
	assign take = valid_s1 && (!res.hit || out_free);

	fspp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.rx_byte    (rx_byte),
		.take       (take),
		.valid_s1   (valid_s1),
		.byte_s1    (byte_s1)
	);

	fspp_frame_step u_frame_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.take     (take),
		.res      (res)
	);

	fspp_out_reg u_out_reg (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (take && res.hit),
		.voltage        (res.voltage),
		.current        (res.current),
		.free           (out_free),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.voltage_tenths (voltage_tenths),
		.current_tenths (current_tenths)
	);

endmodule

>>> tb/framed_sensor_packet_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_sensor_packet_parser_tb
// feeds the parser a byte stream of valid, broken and noisy frames under
// random idling on both channels, predicts each frame reading and checks
// every reading that comes out against the oldest one still due
// ----------------------------------------------------------------------------
module framed_sensor_packet_parser_tb;

	localparam int RUN_LIMIT   = 100000;  // cycles before the run is declared hung
	localparam int RX_TARGET   = 1000;    // rough number of words to send
	localparam int NO_FAULT    = -1;      // frame position index meaning "leave intact"
	localparam int IDLE_PCT    = 30;      // idling chance per cycle on each side
	localparam int CALM_FROM   = 300;     // window with no idling at all
	localparam int CALM_TO     = 800;
	localparam int DRAIN_WAIT  = 8;       // settling wait once every reading due has come out

	// one word waiting to be offered, with an optional hold-off before it
	typedef struct {
		logic [7:0] data;
		bit         hold;
	} rx_word_t;

	// one decoded frame reading
	typedef struct {
		logic [15:0] voltage;
		logic [15:0] current;
	} reading_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        byte_valid     = 1'b0;
	logic [7:0]  rx_byte        = 8'h00;
	logic        result_ready   = 1'b0;
	logic        byte_ready;
	logic        result_valid;
	logic [15:0] voltage_tenths;
	logic [15:0] current_tenths;

	rx_word_t    rx_pending[$];
	reading_t    readings_due[$];
	reading_t    head_reading;
	int          cycle_cnt = 0;
	int          fail_cnt  = 0;
	int          rx_queued = 0;
	bit          calm;

	// parser's view of the frame, kept in step with every accepted word
	fspp_pkg::pos_t frame_pos  = fspp_pkg::POS_HDR0;
	logic [7:0]     frame_csum = 8'h00;
	logic [15:0]    volt_acc   = 16'h0000;
	logic [15:0]    curr_acc   = 16'h0000;

	framed_sensor_packet_parser u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_ready     (byte_ready),
		.rx_byte        (rx_byte),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.voltage_tenths (voltage_tenths),
		.current_tenths (current_tenths)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// both sides run flat out inside the calm window
	assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

	// fold one accepted word into the frame state; a finished frame adds a reading
	function automatic void fold_rx_byte(input logic [7:0] b);
		fspp_pkg::pos_t at;
		bit             restart;
		reading_t       got;
		// a position past the trailer cannot happen, but counts as the first header
		at      = (frame_pos > fspp_pkg::POS_TRAIL) ? fspp_pkg::POS_HDR0 : frame_pos;
		restart = 1'b0;
		case (at)
			fspp_pkg::POS_HDR0: begin
				restart = (b != fspp_pkg::HDR0_BYTE);
			end
			fspp_pkg::POS_HDR1: begin
				restart = (b != fspp_pkg::HDR1_BYTE);
			end
			fspp_pkg::POS_VOLT_L: begin
				volt_acc   = {8'h00, b};
				frame_csum = b;
			end
			fspp_pkg::POS_VOLT_H: begin
				volt_acc   = {b, volt_acc[7:0]};
				frame_csum = frame_csum + b;
			end
			fspp_pkg::POS_CURR_L: begin
				curr_acc   = {8'h00, b};
				frame_csum = frame_csum + b;
			end
			fspp_pkg::POS_CURR_H: begin
				curr_acc   = {b, curr_acc[7:0]};
				frame_csum = frame_csum + b;
			end
			fspp_pkg::POS_SPARE0, fspp_pkg::POS_SPARE1: begin
				frame_csum = frame_csum + b;
			end
			fspp_pkg::POS_CSUM: begin
				restart = (b != frame_csum);
			end
			default: begin
				// trailer: a match completes the frame, either way we start over
				if (b == fspp_pkg::TRAIL_BYTE) begin
					got.voltage = volt_acc;
					got.current = curr_acc;
					readings_due.push_back(got);
				end
				restart = 1'b1;
			end
		endcase
		if (restart) begin
			// the failing word is dropped, the next one is checked as a header
			frame_pos  = fspp_pkg::POS_HDR0;
			frame_csum = 8'h00;
		end else begin
			frame_pos = at + fspp_pkg::pos_t'(1);
		end
	endfunction

	task automatic queue_word(input logic [7:0] b, input bit hold);
		rx_word_t w;
		w.data = b;
		w.hold = hold;
		rx_pending.push_back(w);
		rx_queued++;
	endtask

	// one frame with its proper checksum, optionally with a single word overwritten
	task automatic queue_frame(input logic [15:0] volt, input logic [15:0] curr,
			input logic [7:0] sp0, input logic [7:0] sp1,
			input int bad_at, input logic [7:0] bad_val, input bit hold);
		logic [7:0] w [10];
		int         i;
		w = '{fspp_pkg::HDR0_BYTE, fspp_pkg::HDR1_BYTE,
			volt[7:0], volt[15:8], curr[7:0], curr[15:8],
			sp0, sp1, 8'h00, fspp_pkg::TRAIL_BYTE};
		w[8] = w[2] + w[3] + w[4] + w[5] + w[6] + w[7];
		if (bad_at != NO_FAULT)
			w[bad_at] = bad_val;
		for (i = 0; i < 10; i++)
			queue_word(w[i], hold && (i == 0));
	endtask

	// driver: offers the next word, holds it steady until taken
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			if (byte_valid && byte_ready)
				fold_rx_byte(rx_byte);
			if (!byte_valid || byte_ready) begin
				// a held word waits until every reading owed so far has come out
				if (rx_pending.size() != 0
						&& !(rx_pending[0].hold && readings_due.size() != 0)
						&& (calm || $urandom_range(99) >= IDLE_PCT)) begin
					rx_byte    <= rx_pending[0].data;
					byte_valid <= 1'b1;
					void'(rx_pending.pop_front());
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: takes readings and compares each with the oldest one due
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (readings_due.size() == 0) begin
					$error("unexpected reading: voltage %0d current %0d",
						voltage_tenths, current_tenths);
					fail_cnt++;
				end else begin
					head_reading = readings_due.pop_front();
					if (voltage_tenths !== head_reading.voltage) begin
						$error("voltage_tenths: expected %0d, got %0d",
							head_reading.voltage, voltage_tenths);
						fail_cnt++;
					end
					if (current_tenths !== head_reading.current) begin
						$error("current_tenths: expected %0d, got %0d",
							head_reading.current, current_tenths);
						fail_cnt++;
					end
				end
			end
			result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// watchdog
	initial begin
		while (cycle_cnt < RUN_LIMIT)
			@(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int          pick;
		int          n;
		int          k;
		bit          held_once;
		logic [15:0] volt;
		logic [15:0] curr;

		held_once = 1'b0;

		// directed part
		// stray word that is not a header
		queue_word(8'h55, 1'b0);
		// every data bit set, checksum wraps round
		queue_frame(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, NO_FAULT, 8'h00, 1'b0);
		// repeated first header: the second one fails and is not looked at again,
		// so the second header word then fails as a first header
		queue_word(fspp_pkg::HDR0_BYTE, 1'b0);
		queue_word(fspp_pkg::HDR0_BYTE, 1'b0);
		queue_word(fspp_pkg::HDR1_BYTE, 1'b0);
		// wrong checksum, then a trailer word seen as a header
		queue_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 8, 8'h01, 1'b0);
		// wrong trailer that looks like a first header, dropped all the same
		queue_frame(16'h0000, 16'h0000, 8'h00, 8'h00, 9, fspp_pkg::HDR0_BYTE, 1'b0);
		// all-zero frame sent only once the link has drained
		queue_frame(16'h0000, 16'h0000, 8'h00, 8'h00, NO_FAULT, 8'h00, 1'b1);
		// fields at opposite extremes, back to back
		queue_frame(16'hFFFF, 16'h0000, 8'h00, 8'hFF, NO_FAULT, 8'h00, 1'b0);

		// random part: mostly good frames, some broken ones, some line noise
		while (rx_queued < RX_TARGET) begin
			pick = $urandom_range(99);
			volt = 16'($urandom);
			curr = 16'($urandom);
			if (pick < 65) begin
				queue_frame(volt, curr, 8'($urandom), 8'($urandom), NO_FAULT, 8'h00,
					!held_once && rx_queued > RX_TARGET / 2);
				if (rx_queued > RX_TARGET / 2)
					held_once = 1'b1;
			end else if (pick < 85) begin
				queue_frame(volt, curr, 8'($urandom), 8'($urandom),
					$urandom_range(9), 8'($urandom), 1'b0);
			end else if (pick < 92) begin
				// frame cut short partway through
				n = $urandom_range(1, 9);
				queue_word(fspp_pkg::HDR0_BYTE, 1'b0);
				for (k = 1; k < n; k++)
					queue_word((k == 1) ? fspp_pkg::HDR1_BYTE : 8'($urandom), 1'b0);
			end else begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					queue_word(($urandom_range(3) == 0) ? fspp_pkg::HDR0_BYTE
						: 8'($urandom), 1'b0);
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_pending.size() != 0 || byte_valid)
			@(posedge clk);
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
